// File: hw/rtl/pfa_pkg.sv
// Package for the page frame allocator: field widths, tdata layout,
// status and opcode codes, and the command and status structs between
// the controller and the datapath. No dependencies.
package pfa_pkg;

  // Table and stack sizes
  localparam int REGION_SLOTS = 8;
  localparam int STACK_DEPTH  = 1024;

  // Field widths
  localparam int FRAME_W  = 52;
  localparam int SLOT_W   = 3;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  // Derived widths
  localparam int IDX_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  // Input tdata layout, lowest field first
  localparam int SLOT_LSB   = 0;
  localparam int BASE_LSB   = SLOT_LSB + SLOT_W;
  localparam int PAGES_LSB  = BASE_LSB + FRAME_W;
  localparam int USABLE_LSB = PAGES_LSB + FRAME_W;
  localparam int FREED_LSB  = USABLE_LSB + 1;
  localparam int IN_FIELDS_W = FREED_LSB + FRAME_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata holds the frame number, padded to bytes
  localparam int OUT_DATA_W = ((FRAME_W + 7) / 8) * 8;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_FULL   = 2'd2,
    ST_LOADED = 2'd3
  } status_t;

  // Source of the result frame number
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_STACK,
    RES_WALK
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_region;
    logic     push;
    logic     pop;
    logic     walk_clear;
    logic     walk_next;
    logic     res_load;
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;
  } pfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stack_empty;
    logic stack_full;
    logic walk_hit;
    logic walk_last;
  } pfa_stat_t;

endpackage

// File: hw/rtl/page_frame_allocator.sv
// Page frame allocator (free stack with a region walk as fallback): one
// request in, one result out. A load request, a free and an unknown opcode
// are written to the result register and then to the output register; an
// allocate served from the free stack first passes the registered read of
// the stack memory; an allocate served by the walk first examines k region
// entries (k from 1 to REGION_SLOTS), one per cycle. One request is in work
// at a time; the output register lets the next request enter while a result
// still waits to be taken. The free stack memory needs no clearing pass
// after reset.
module page_frame_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata, from bit 0: region_slot[2:0], region_base[51:0],
  // region_pages[51:0], region_usable, freed_frame[51:0]
  input  logic [pfa_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [pfa_pkg::OPCODE_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata, from bit 0: frame[51:0], zero padding
  output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status[1:0]
  output logic [pfa_pkg::STATUS_W-1:0]   m_tuser
);
  import pfa_pkg::*;

  pfa_cmd_t  cmd;
  pfa_stat_t stat;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfa_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // Only one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  // Never push onto a full stack
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.stack_full)
    else $error("push onto full free stack");

  // Never pop an empty stack
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stat.stack_empty)
    else $error("pop from empty free stack");

  // A new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

endmodule

// File: hw/rtl/pfa_datapath.sv
// Datapath of the page frame allocator: region table, free stack memory,
// stack count, last frame, region walk and the result and output registers.
// Depends on pfa_pkg.
module pfa_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pfa_pkg::IN_DATA_W-1:0] s_tdata,
  input  pfa_pkg::pfa_cmd_t            cmd,
  output pfa_pkg::pfa_stat_t           stat,
  output logic [pfa_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [pfa_pkg::STATUS_W-1:0]   m_tuser
);
  import pfa_pkg::*;

  // Request fields
  logic [SLOT_W-1:0]  in_slot;
  logic [FRAME_W-1:0] in_base;
  logic [FRAME_W-1:0] in_pages;
  logic               in_usable;
  logic [FRAME_W-1:0] in_freed;

  assign in_slot   = s_tdata[SLOT_LSB +: SLOT_W];
  assign in_base   = s_tdata[BASE_LSB +: FRAME_W];
  assign in_pages  = s_tdata[PAGES_LSB +: FRAME_W];
  assign in_usable = s_tdata[USABLE_LSB];
  assign in_freed  = s_tdata[FREED_LSB +: FRAME_W];

  // Region table: base, last frame of the region, and a live flag
  logic [FRAME_W-1:0]      reg_base [REGION_SLOTS];
  logic [FRAME_W-1:0]      reg_end  [REGION_SLOTS];
  logic [REGION_SLOTS-1:0] reg_live;

  logic [IDX_W-1:0]   slot_idx;
  logic               slot_ok;
  logic [FRAME_W:0]   end_sum;
  logic [FRAME_W-1:0] end_frame;

  assign slot_idx = IDX_W'(in_slot);
  assign slot_ok  = 32'(in_slot) < REGION_SLOTS;

  // Last frame of the loaded region, clipped at the top of frame space
  assign end_sum   = {1'b0, in_base} + {1'b0, in_pages} - (FRAME_W+1)'(1);
  assign end_frame = end_sum[FRAME_W] ? {FRAME_W{1'b1}} : end_sum[FRAME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_live <= '0;
    end else if (cmd.load_region && slot_ok) begin
      reg_live[slot_idx] <= in_usable && (in_pages != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_region && slot_ok) begin
      reg_base[slot_idx] <= in_base;
      reg_end[slot_idx]  <= end_frame;
    end
  end

  // Free stack memory, one write and one registered read port
  logic [FRAME_W-1:0] stack_mem [STACK_DEPTH];
  logic [FRAME_W-1:0] stack_rd;
  logic [CNT_W-1:0]   stack_count;
  logic [ADDR_W-1:0]  push_addr;
  logic [ADDR_W-1:0]  pop_addr;

  assign push_addr = stack_count[ADDR_W-1:0];
  assign pop_addr  = ADDR_W'(stack_count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[push_addr] <= in_freed;
    end
    if (cmd.pop) begin
      stack_rd <= stack_mem[pop_addr];
    end
  end

  // Track the stack fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
    end else if (cmd.push) begin
      stack_count <= stack_count + CNT_W'(1);
    end else if (cmd.pop) begin
      stack_count <= stack_count - CNT_W'(1);
    end
  end

  assign stat.stack_empty = (stack_count == '0);
  assign stat.stack_full  = (stack_count == CNT_W'(STACK_DEPTH));

  // Region walk, one entry per cycle
  logic [IDX_W-1:0]   walk_idx;
  logic [FRAME_W-1:0] last_frame;
  logic [FRAME_W-1:0] cur_base;
  logic [FRAME_W-1:0] cur_end;
  logic               below_base;
  logic               below_end;
  logic [FRAME_W-1:0] walk_frame;

  always_ff @(posedge clk) begin
    if (cmd.walk_clear) begin
      walk_idx <= '0;
    end else if (cmd.walk_next) begin
      walk_idx <= walk_idx + IDX_W'(1);
    end
  end

  assign cur_base   = reg_base[walk_idx];
  assign cur_end    = reg_end[walk_idx];
  assign below_base = last_frame < cur_base;
  assign below_end  = last_frame < cur_end;
  assign walk_frame = below_base ? cur_base : last_frame + FRAME_W'(1);

  assign stat.walk_hit  = reg_live[walk_idx] && (below_base || below_end);
  assign stat.walk_last = (walk_idx == IDX_W'(REGION_SLOTS - 1));

  // Advance the last frame on a walk hit
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame <= '0;
    end else if (cmd.res_load && cmd.res_sel == RES_WALK) begin
      last_frame <= walk_frame;
    end
  end

  // Result register
  logic [FRAME_W-1:0] res_frame;
  status_t            res_status;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        RES_STACK: res_frame <= stack_rd;
        RES_WALK:  res_frame <= walk_frame;
        default:   res_frame <= '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_DATA_W'(res_frame);
      m_tuser <= res_status;
    end
  end

endmodule

// File: hw/rtl/pfa_ctrl.sv
// Controller of the page frame allocator: request decode, region walk
// sequencing and the output valid flag.
// Depends on pfa_pkg.
module pfa_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [pfa_pkg::OPCODE_W-1:0] s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  pfa_pkg::pfa_stat_t           stat,
  output pfa_pkg::pfa_cmd_t            cmd
);
  import pfa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Decode requests and step the sequence
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (s_tuser)
            OP_LOAD: begin
              cmd.load_region = 1'b1;
              cmd.res_load    = 1'b1;
              cmd.res_sel     = RES_ZERO;
              cmd.res_status  = ST_LOADED;
              state_next      = S_RESP;
            end
            OP_ALLOC: begin
              if (!stat.stack_empty) begin
                cmd.pop    = 1'b1;
                state_next = S_POP;
              end else begin
                cmd.walk_clear = 1'b1;
                state_next     = S_WALK;
              end
            end
            OP_FREE: begin
              cmd.push       = !stat.stack_full;
              cmd.res_load   = 1'b1;
              cmd.res_sel    = RES_ZERO;
              cmd.res_status = stat.stack_full ? ST_FULL : ST_OK;
              state_next     = S_RESP;
            end
            default: begin
              cmd.res_load   = 1'b1;
              cmd.res_sel    = RES_ZERO;
              cmd.res_status = ST_OK;
              state_next     = S_RESP;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_STACK;
        cmd.res_status = ST_OK;
        state_next     = S_RESP;
      end
      S_WALK: begin
        if (stat.walk_hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_WALK;
          cmd.res_status = ST_OK;
          state_next     = S_RESP;
        end else if (stat.walk_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_ZERO;
          cmd.res_status = ST_OOM;
          state_next     = S_RESP;
        end else begin
          cmd.walk_next = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= cmd.out_load || (m_tvalid && !m_tready);
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for page_frame_allocator: directed region, walk and
// stack requests, then random traffic with stalls on both sides.
// Depends on pfa_pkg and the page_frame_allocator RTL.
module tb;
  import pfa_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NONE    = 2'd3;
  localparam logic [FRAME_W-1:0]  FRAME_MASK = '1;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    status_t            status;
  } answer_t;

  typedef struct {
    logic [OPCODE_W-1:0]  op;
    logic [IN_DATA_W-1:0] data;
    bit                   typed;
    answer_t              want;
  } req_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OPCODE_W-1:0]   s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  // Shadow allocator state
  logic [FRAME_W-1:0] rgn_base   [REGION_SLOTS];
  logic [FRAME_W-1:0] rgn_pages  [REGION_SLOTS];
  logic               rgn_usable [REGION_SLOTS];
  logic [FRAME_W-1:0] free_frames [STACK_DEPTH];
  int                 stack_fill;
  logic [FRAME_W-1:0] last_frame;

  answer_t  answers_due [$];
  req_row_t script [$];
  int       errors = 0;
  int       reported = 0;
  int       seen_status [4] = '{0, 0, 0, 0};
  bit       hold_off_req = 1'b0;
  bit       tx_steady = 1'b0;
  bit       rx_steady = 1'b0;

  page_frame_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Answer that the allocator gives to one request; advances the shadow state
  function automatic answer_t allocator_answer(input logic [OPCODE_W-1:0] op,
                                               input logic [IN_DATA_W-1:0] d);
    answer_t            a;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W:0]   span_end;
    logic [FRAME_W-1:0] top;
    bit                 hit;
    a.frame  = '0;
    a.status = ST_OK;
    hit      = 1'b0;
    case (op)
      OP_LOAD: begin
        slot = d[SLOT_LSB +: SLOT_W];
        if (slot < REGION_SLOTS) begin
          rgn_base[slot]   = d[BASE_LSB +: FRAME_W];
          rgn_pages[slot]  = d[PAGES_LSB +: FRAME_W];
          rgn_usable[slot] = d[USABLE_LSB];
        end
        a.status = ST_LOADED;
      end
      OP_ALLOC: begin
        if (stack_fill > 0) begin
          stack_fill--;
          a.frame = free_frames[stack_fill];
        end else begin
          // Walk regions in slot order for the first frame above last_frame
          for (int i = 0; i < REGION_SLOTS && !hit; i++) begin
            if (rgn_usable[i] && rgn_pages[i] != '0) begin
              span_end = {1'b0, rgn_base[i]} + {1'b0, rgn_pages[i]} - 1'b1;
              top = (span_end > {1'b0, FRAME_MASK}) ? FRAME_MASK : span_end[FRAME_W-1:0];
              if (last_frame < rgn_base[i]) begin
                a.frame = rgn_base[i];
                hit = 1'b1;
              end else if (last_frame < top) begin
                a.frame = last_frame + 1'b1;
                hit = 1'b1;
              end
            end
          end
          if (hit) last_frame = a.frame;
          else a.status = ST_OOM;
        end
      end
      OP_FREE: begin
        if (stack_fill < STACK_DEPTH) begin
          free_frames[stack_fill] = d[FREED_LSB +: FRAME_W];
          stack_fill++;
        end else begin
          a.status = ST_FULL;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_req(input logic [SLOT_W-1:0] slot,
                                                     input logic [FRAME_W-1:0] base,
                                                     input logic [FRAME_W-1:0] pages,
                                                     input logic usable,
                                                     input logic [FRAME_W-1:0] freed);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[SLOT_LSB +: SLOT_W]   = slot;
    d[BASE_LSB +: FRAME_W]  = base;
    d[PAGES_LSB +: FRAME_W] = pages;
    d[USABLE_LSB]           = usable;
    d[FREED_LSB +: FRAME_W] = freed;
    return d;
  endfunction

  // Frame numbers: small, full range, near the top, near last_frame, extremes
  function automatic logic [FRAME_W-1:0] rand_frame();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return FRAME_W'(r[5:0]);
      1, 2:    return r[FRAME_W-1:0];
      3:       return FRAME_MASK - FRAME_W'(r[7:0]);
      4:       return last_frame + FRAME_W'(r[2:0]) - FRAME_W'(2);
      default: return r[8] ? FRAME_MASK : '0;
    endcase
  endfunction

  // Page counts: mostly a handful, sometimes huge
  function automatic logic [FRAME_W-1:0] rand_pages();
    logic [63:0] r;
    int          pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 6) return FRAME_W'($urandom_range(0, 6));
    if (pick < 8) return r[FRAME_W-1:0];
    if (pick < 9) return FRAME_MASK;
    return FRAME_W'(r[15:0]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
                         input logic [FRAME_W-1:0] base, input logic [FRAME_W-1:0] pages,
                         input logic usable, input logic [FRAME_W-1:0] freed,
                         input bit typed, input logic [FRAME_W-1:0] frame,
                         input status_t status);
    req_row_t row;
    row.op          = op;
    row.data        = pack_req(slot, base, pages, usable, freed);
    row.typed       = typed;
    row.want.frame  = frame;
    row.want.status = status;
    script.push_back(row);
  endtask

  // Offer one request, wait for the handshake, then idle for a random gap
  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [IN_DATA_W-1:0] data,
                          input bit typed, input answer_t want);
    answer_t a;
    int      gap;
    @(negedge clk);
    s_tuser  <= op;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    a = allocator_answer(op, data);
    answers_due.push_back(typed ? want : a);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_answers();
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin : receiver
    int gap;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end else if (rx_steady) begin
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each answer taken with the oldest one due
  always @(posedge clk) begin : answer_check
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen_status[m_tuser]++;
      if (answers_due.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("%0t: answer with nothing due: frame %h status %0d",
                   $realtime, m_tdata, m_tuser);
        end
      end else begin
        want = answers_due.pop_front();
        if (m_tdata !== {{(OUT_DATA_W - FRAME_W){1'b0}}, want.frame} ||
            m_tuser !== want.status) begin
          errors++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("%0t: answer mismatch: frame %h status %0d, wanted frame %h status %0d",
                     $realtime, m_tdata, m_tuser, want.frame, want.status);
          end
        end
      end
    end
  end

  // Stop the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no request or answer moved for %0d cycles", quiet);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [OPCODE_W-1:0]  op;
    logic [IN_DATA_W-1:0] data;
    answer_t              none;
    int                   r;
    none.frame  = '0;
    none.status = ST_OK;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_LOAD;
    for (int i = 0; i < REGION_SLOTS; i++) begin
      rgn_base[i]   = '0;
      rgn_pages[i]  = '0;
      rgn_usable[i] = 1'b0;
    end
    stack_fill = 0;
    last_frame = '0;

    // Directed requests: empty start, stack, walk, clipping, unknown opcode
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, 0, ST_OOM);
    add_row(OP_FREE,  0, 0, 0, 0, 0, 1, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, 0, ST_OK);
    add_row(OP_LOAD,  0, 0, 4, 1, 0, 1, 0, ST_LOADED);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_LOAD,  1, 100, 0, 1, 0, 1, 0, ST_LOADED);
    add_row(OP_LOAD,  2, 50, 5, 0, 0, 1, 0, ST_LOADED);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_LOAD,  7, FRAME_MASK - 2, FRAME_MASK, 1, 0, 1, 0, ST_LOADED);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_FREE,  0, 0, 0, 0, FRAME_MASK, 1, 0, ST_OK);
    add_row(OP_FREE,  0, 0, 0, 0, 52'h5_5555_5555_5555, 1, 0, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, 52'h5_5555_5555_5555, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1, FRAME_MASK, ST_OK);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);
    add_row(OP_NONE,  '1, FRAME_MASK, FRAME_MASK, 1, FRAME_MASK, 1, 0, ST_OK);
    add_row(OP_LOAD,  '1, FRAME_MASK, FRAME_MASK, 1, FRAME_MASK, 1, 0, ST_LOADED);
    add_row(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0, ST_OK);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_req(script[i].op, script[i].data, script[i].typed,
                                 script[i].want);

    // Random traffic, mostly well-formed allocator use
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) hold_off_req = 1'b1;
      // Pause the sender: drop the request line, then wait for every answer
      if (n == 400) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_for_answers();
      end
      tx_steady = (n >= 500 && n < 580);
      rx_steady = tx_steady;
      // Fill the free stack past its depth, then pop a few back
      if (n == 700) begin
        while (stack_fill < STACK_DEPTH) send_req(OP_FREE,
            pack_req(SLOT_W'($urandom_range(0, 7)), rand_frame(), rand_pages(),
                     1'($urandom_range(0, 1)), rand_frame()), 0, none);
        repeat (6) send_req(OP_FREE, pack_req(0, 0, 0, 0, rand_frame()), 0, none);
        repeat (20) send_req(OP_ALLOC, pack_req(0, 0, 0, 0, 0), 0, none);
      end
      r  = $urandom_range(0, 99);
      op = (r < 20) ? OP_LOAD : (r < 65) ? OP_ALLOC : (r < 93) ? OP_FREE : OP_NONE;
      data = pack_req(SLOT_W'($urandom_range(0, 7)), rand_frame(), rand_pages(),
                      1'($urandom_range(0, 1)), rand_frame());
      send_req(op, data, 0, none);
    end

    // Drain: hold the input idle, wait for every answer, then a little longer
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("answers: %0d ok, %0d out of memory, %0d stack full, %0d region loads",
             seen_status[ST_OK], seen_status[ST_OOM], seen_status[ST_FULL],
             seen_status[ST_LOADED]);
    $display("covered region walks, stack push/pop to full depth and long output stalls");
    if (errors == 0 && answers_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", errors, answers_due.size());
      $display("tb failed");
    end
    $finish;
  end

endmodule
